// ----- rtl/crl_pkg.sv -----
// ----------------------------------------------------------------------------
// crl_pkg: shared types and constants of the color ramp lookup
// Item payload structs, result status codes and the record that travels
// alongside the weight divider.
// ----------------------------------------------------------------------------
package crl_pkg;

  // Fixed field widths
  localparam int POS_W   = 16;
  localparam int COLOR_W = 32;

  // Item modes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_APPEND = 1'b1;

  // Opaque red for an empty table
  localparam logic [COLOR_W-1:0] EMPTY_COLOR = 32'hFF00_00FF;

  typedef enum logic [1:0] {
    ST_COLOR    = 2'd0,
    ST_APPENDED = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    logic                     mode;
    logic signed [POS_W-1:0]  position;
    logic [COLOR_W-1:0]       below_color;
    logic [COLOR_W-1:0]       match_color;
    logic [COLOR_W-1:0]       above_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
    status_t    status;
  } out_item_t;

  // Color source picked for a lookup
  typedef enum logic [4:0] {
    SEL_CONST = 5'b00001,
    SEL_ABOVE = 5'b00010,
    SEL_EXACT = 5'b00100,
    SEL_BELOW = 5'b01000,
    SEL_BLEND = 5'b10000
  } sel_t;

  // Record carried next to the divider
  typedef struct packed {
    logic               blend;
    status_t            status;
    logic [COLOR_W-1:0] direct;
    logic [COLOR_W-1:0] right_below;
    logic [COLOR_W-1:0] left_above;
  } tag_t;

endpackage

// ----- rtl/color_ramp_lookup.sv -----
// ----------------------------------------------------------------------------
// color_ramp_lookup: piecewise linear pseudocolor map
// Appends build a table of increasing breakpoints; lookups return the exact,
// edge or Q-format blended color for a value.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid, in_ready, in_data    | in
//   result  | out_valid, out_ready, out_data | out
//
// One item enters per cycle while out_ready lets the pipeline move; each
// item passes the flag, RAM read and operand stages, the one-bit-per-stage
// weight divider and the blend stage. Reset clears the breakpoint count and
// all valid bits; the color RAMs keep their contents. A stall on out_ready
// freezes the whole pipeline at once, so in_ready follows the output register.
// ----------------------------------------------------------------------------
module color_ramp_lookup #(
  parameter int MAX_ENTRIES     = 8,
  parameter int BLEND_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  crl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crl_pkg::out_item_t out_data
);
  import crl_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FW = BLEND_FRAC_BITS;

  logic adv;
  logic accept;
  logic app_ok;
  logic app_we;

  logic [CW-1:0]                count_r;
  logic signed [POS_W-1:0]      last_pos_r;
  logic signed [POS_W-1:0]      pos_r [MAX_ENTRIES];

  // Stage A registers
  logic                         a_v_r;
  logic                         a_look_r;
  status_t                      a_status_r;
  logic [CW-1:0]                a_count_r;
  logic signed [POS_W-1:0]      a_x_r;
  logic [MAX_ENTRIES-1:0]       a_gt_r;
  logic [MAX_ENTRIES-1:0]       a_eq_r;
  logic [MAX_ENTRIES-1:0]       gt_nxt;
  logic [MAX_ENTRIES-1:0]       eq_nxt;

  // Stage B registers
  logic                         b_v_r;
  status_t                      b_status_r;
  sel_t                         b_sel_r;
  sel_t                         sel_nxt;
  logic [COLOR_W-1:0]           b_const_r;
  logic signed [POS_W-1:0]      b_x_r;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                above_idx;

  logic [COLOR_W-1:0]           below_q, exact_q, above_q;
  logic [POS_W-1:0]             posr_q, posl_q;

  // Stage C registers
  logic                         c_v_r;
  tag_t                         c_tag_r;
  tag_t                         tag_nxt;
  logic [POS_W:0]               c_num_r;
  logic [POS_W:0]               c_span_r;

  logic                         d_v;
  logic [FW-1:0]                d_w;
  tag_t                         d_tag;

  logic                         out_valid_r;
  out_item_t                    out_data_r;
  out_item_t                    out_nxt;

  // Whole pipeline moves together
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // Append check against the last held position
  assign app_ok = (count_r < CW'(MAX_ENTRIES)) &&
                  ((count_r == '0) || (in_data.position > last_pos_r));
  assign app_we = accept && (in_data.mode == MODE_APPEND) && app_ok;

  // Table count and position flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (app_we) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (app_we) begin
      last_pos_r                <= in_data.position;
      pos_r[count_r[AW-1:0]]    <= in_data.position;
    end
  end

  // Compare lanes, one per entry
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      gt_nxt[k] = (CW'(k) < count_r) && (in_data.position > pos_r[k]);
      eq_nxt[k] = (CW'(k) < count_r) && (in_data.position == pos_r[k]);
    end
  end

  // Stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_look_r   <= (in_data.mode == MODE_LOOKUP);
      a_status_r <= (in_data.mode == MODE_LOOKUP) ? ST_COLOR :
                    (app_ok ? ST_APPENDED : ST_REJECTED);
      a_count_r  <= count_r;
      a_x_r      <= in_data.position;
      a_gt_r     <= gt_nxt;
      a_eq_r     <= eq_nxt;
    end
  end

  // Interval index and color source
  always_comb begin
    idx = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      idx = idx + CW'(a_gt_r[k]);
    end
    above_idx = (idx == a_count_r) ? a_count_r - 1'b1 : idx - 1'b1;
    priority if (!a_look_r)          sel_nxt = SEL_CONST;
    else if (a_count_r == '0)        sel_nxt = SEL_CONST;
    else if (idx == a_count_r)       sel_nxt = SEL_ABOVE;
    else if (|a_eq_r)                sel_nxt = SEL_EXACT;
    else if (idx == '0)              sel_nxt = SEL_BELOW;
    else                             sel_nxt = SEL_BLEND;
  end

  // Color and position RAMs, read with stage A address
  crl_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_ENTRIES)) u_below (
    .clk(clk), .we(app_we), .waddr(count_r[AW-1:0]), .wdata(in_data.below_color),
    .re(adv), .raddr(idx[AW-1:0]), .rdata(below_q)
  );

  crl_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_ENTRIES)) u_exact (
    .clk(clk), .we(app_we), .waddr(count_r[AW-1:0]), .wdata(in_data.match_color),
    .re(adv), .raddr(idx[AW-1:0]), .rdata(exact_q)
  );

  crl_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_ENTRIES)) u_above (
    .clk(clk), .we(app_we), .waddr(count_r[AW-1:0]), .wdata(in_data.above_color),
    .re(adv), .raddr(above_idx[AW-1:0]), .rdata(above_q)
  );

  crl_ram #(.WIDTH(POS_W), .DEPTH(MAX_ENTRIES)) u_posr (
    .clk(clk), .we(app_we), .waddr(count_r[AW-1:0]), .wdata(in_data.position),
    .re(adv), .raddr(idx[AW-1:0]), .rdata(posr_q)
  );

  crl_ram #(.WIDTH(POS_W), .DEPTH(MAX_ENTRIES)) u_posl (
    .clk(clk), .we(app_we), .waddr(count_r[AW-1:0]), .wdata(in_data.position),
    .re(adv), .raddr(idx[AW-1:0] - 1'b1), .rdata(posl_q)
  );

  // Stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_status_r <= a_status_r;
      b_sel_r    <= sel_nxt;
      b_const_r  <= a_look_r ? EMPTY_COLOR : '0;
      b_x_r      <= a_x_r;
    end
  end

  // Operand pick for the divider and the blend
  always_comb begin
    tag_nxt.blend       = (b_sel_r == SEL_BLEND);
    tag_nxt.status      = b_status_r;
    tag_nxt.right_below = below_q;
    tag_nxt.left_above  = above_q;
    unique case (b_sel_r)
      SEL_ABOVE: tag_nxt.direct = above_q;
      SEL_EXACT: tag_nxt.direct = exact_q;
      SEL_BELOW: tag_nxt.direct = below_q;
      SEL_CONST: tag_nxt.direct = b_const_r;
      default:   tag_nxt.direct = '0;
    endcase
  end

  // Stage C
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag_r  <= tag_nxt;
      c_num_r  <= {b_x_r[POS_W-1], b_x_r} - {posl_q[POS_W-1], posl_q};
      c_span_r <= {posr_q[POS_W-1], posr_q} - {posl_q[POS_W-1], posl_q};
    end
  end

  // Weight divider
  crl_div #(.FRAC_W(FW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(c_v_r), .in_num(c_num_r), .in_span(c_span_r), .in_tag(c_tag_r),
    .out_valid(d_v), .out_q(d_w), .out_tag(d_tag)
  );

  // Per-channel blend, rounding half up
  always_comb begin
    logic [31:0] mixed;
    logic [FW+8:0] acc;
    mixed = '0;
    for (int c = 0; c < 4; c++) begin
      acc = (FW+9)'(d_w) * (FW+9)'(d_tag.right_below[c*8 +: 8])
          + ((FW+9)'(1) << FW) * (FW+9)'(d_tag.left_above[c*8 +: 8])
          - (FW+9)'(d_w) * (FW+9)'(d_tag.left_above[c*8 +: 8])
          + ((FW+9)'(1) << (FW - 1));
      mixed[c*8 +: 8] = acc[FW +: 8];
    end
    if (!d_tag.blend) begin
      mixed = d_tag.direct;
    end
    out_nxt.red     = mixed[31:24];
    out_nxt.green   = mixed[23:16];
    out_nxt.blue    = mixed[15:8];
    out_nxt.opacity = mixed[7:0];
    out_nxt.status  = d_tag.status;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("breakpoint count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(app_we))
    else $error("breakpoint count moved without an accepted append");

  a_append_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_COLOR) |->
      (out_data.red == 8'd0 && out_data.opacity == 8'd0))
    else $error("append result carries a color");

endmodule

// ----- rtl/crl_ram.sv -----
// ----------------------------------------------------------------------------
// crl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crl_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/crl_div.sv -----
// ----------------------------------------------------------------------------
// crl_div: pipelined restoring divider for the blend weight
// Produces floor((num << FRAC_W) / span), one quotient bit per stage, for
// num < span. A tag record rides along with each item.
// ----------------------------------------------------------------------------
module crl_div #(
  parameter int FRAC_W = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [crl_pkg::POS_W:0] in_num,
  input  logic [crl_pkg::POS_W:0] in_span,
  input  crl_pkg::tag_t           in_tag,
  output logic                    out_valid,
  output logic [FRAC_W-1:0]       out_q,
  output crl_pkg::tag_t           out_tag
);
  import crl_pkg::*;

  localparam int DW = POS_W + 1;

  logic          v_r    [FRAC_W+1];
  logic [DW-1:0] rem_r  [FRAC_W+1];
  logic [DW-1:0] span_r [FRAC_W+1];
  logic [FRAC_W-1:0] q_r [FRAC_W+1];
  tag_t          tag_r  [FRAC_W+1];

  // Stage 0 is the input itself
  always_comb begin
    v_r[0]    = in_valid;
    rem_r[0]  = in_num;
    span_r[0] = in_span;
    q_r[0]    = '0;
    tag_r[0]  = in_tag;
  end

  for (genvar k = 0; k < FRAC_W; k++) begin : g_stage
    logic [DW:0]       shifted;
    logic [DW:0]       diff;
    logic              take;
    logic [DW-1:0]     rem_nxt;
    logic [FRAC_W-1:0] q_nxt;

    // One quotient bit: shift, trial subtract, restore
    always_comb begin
      shifted = {rem_r[k], 1'b0};
      diff    = shifted - {1'b0, span_r[k]};
      take    = (shifted >= {1'b0, span_r[k]});
      rem_nxt = take ? diff[DW-1:0] : shifted[DW-1:0];
      q_nxt   = {q_r[k][FRAC_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        span_r[k+1] <= span_r[k];
        q_r[k+1]    <= q_nxt;
        tag_r[k+1]  <= tag_r[k];
      end
    end
  end

  assign out_valid = v_r[FRAC_W];
  assign out_q     = q_r[FRAC_W];
  assign out_tag   = tag_r[FRAC_W];

endmodule

// ----- sim/color_ramp_lookup_test.sv -----
// ----------------------------------------------------------------------------
// color_ramp_lookup_test: self-checking regression of the color ramp lookup
// Drives append and lookup items through the valid/ready input channel,
// predicts each result from a local copy of the breakpoint table and checks
// every result field against the oldest prediction, with random idling on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module color_ramp_lookup_test;
  import crl_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int FRAC_BITS   = 8;
  localparam int LATENCY     = FRAC_BITS + 4;
  localparam int RANDOM_ITEMS = 600;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  color_ramp_lookup uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Local copy of the breakpoint table
  logic signed [POS_W-1:0] ramp_pos [TABLE_DEPTH];
  logic [COLOR_W-1:0]      ramp_below [TABLE_DEPTH];
  logic [COLOR_W-1:0]      ramp_exact [TABLE_DEPTH];
  logic [COLOR_W-1:0]      ramp_above [TABLE_DEPTH];
  int                      ramp_count;

  out_item_t expected_colors [$];
  int        error_count;
  int        result_count;
  int        lookup_count;
  int        append_count;
  int        reject_count;
  int        blend_count;
  bit        quiet_phase;
  bit        hold_results;

  function automatic out_item_t color_item(logic [COLOR_W-1:0] c, status_t st);
    out_item_t r;
    r.red     = c[31:24];
    r.green   = c[23:16];
    r.blue    = c[15:8];
    r.opacity = c[7:0];
    r.status  = st;
    return r;
  endfunction

  // Mix two colors by a Q8 weight, rounding half up
  function automatic logic [COLOR_W-1:0] mix_colors(logic [COLOR_W-1:0] rb,
                                                    logic [COLOR_W-1:0] la,
                                                    longint w);
    logic [COLOR_W-1:0] r;
    longint ch;
    r = '0;
    for (int sh = 0; sh < 32; sh += 8) begin
      ch = (w * rb[sh+:8] + ((64'sd1 << FRAC_BITS) - w) * la[sh+:8]
            + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (ch > 255) ch = 255;
      r[sh+:8] = ch[7:0];
    end
    return r;
  endfunction

  // Predict one result and update the table copy
  function automatic out_item_t map_item(in_item_t it);
    longint x, xl, xr, w;
    int i;
    x = it.position;
    if (it.mode == MODE_APPEND) begin
      if (ramp_count >= TABLE_DEPTH ||
          (ramp_count > 0 && x <= longint'(ramp_pos[ramp_count-1]))) begin
        reject_count++;
        return color_item('0, ST_REJECTED);
      end
      ramp_pos[ramp_count]   = it.position;
      ramp_below[ramp_count] = it.below_color;
      ramp_exact[ramp_count] = it.match_color;
      ramp_above[ramp_count] = it.above_color;
      ramp_count++;
      append_count++;
      return color_item('0, ST_APPENDED);
    end
    lookup_count++;
    if (ramp_count == 0) return color_item(EMPTY_COLOR, ST_COLOR);
    for (i = 0; i < ramp_count; i++)
      if (x <= longint'(ramp_pos[i])) break;
    if (i >= ramp_count) return color_item(ramp_above[ramp_count-1], ST_COLOR);
    if (x == longint'(ramp_pos[i])) return color_item(ramp_exact[i], ST_COLOR);
    if (i == 0) return color_item(ramp_below[0], ST_COLOR);
    xl = ramp_pos[i-1];
    xr = ramp_pos[i];
    w = ((x - xl) << FRAC_BITS) / (xr - xl);
    blend_count++;
    return color_item(mix_colors(ramp_below[i], ramp_above[i-1], w), ST_COLOR);
  endfunction

  // Directed rows; has_check marks rows whose result is typed in
  typedef struct {
    in_item_t  item;
    bit        has_check;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic in_item_t make_item(logic m, logic signed [POS_W-1:0] p,
                                         logic [31:0] b, logic [31:0] e,
                                         logic [31:0] a);
    in_item_t it;
    it.mode = m; it.position = p;
    it.below_color = b; it.match_color = e; it.above_color = a;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit chk, out_item_t want);
    stim_row_t r;
    r.item = it; r.has_check = chk; r.want = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    out_item_t none;
    none = '0;
    // empty table, extremes of position
    add_row(make_item(MODE_LOOKUP, 16'sh8000, '1, '1, '1), 1,
            color_item(EMPTY_COLOR, ST_COLOR));
    add_row(make_item(MODE_LOOKUP, 16'sh7FFF, '0, '0, '0), 1,
            color_item(EMPTY_COLOR, ST_COLOR));
    // first breakpoint at the minimum
    add_row(make_item(MODE_APPEND, 16'sh8000, 32'h00000000, 32'hFFFFFFFF,
            32'h00FF00FF), 1, color_item('0, ST_APPENDED));
    add_row(make_item(MODE_LOOKUP, 16'sh8000, '0, '0, '0), 1,
            color_item(32'hFFFFFFFF, ST_COLOR));
    // equal position rejected
    add_row(make_item(MODE_APPEND, 16'sh8000, '1, '1, '1), 1,
            color_item('0, ST_REJECTED));
    add_row(make_item(MODE_APPEND, -16'sd100, 32'hFF00FF00, 32'h12345678,
            32'hA5A5A5A5), 1, color_item('0, ST_APPENDED));
    // lower position rejected
    add_row(make_item(MODE_APPEND, -16'sd200, '1, '1, '1), 1,
            color_item('0, ST_REJECTED));
    add_row(make_item(MODE_LOOKUP, -16'sd101, '0, '0, '0), 0, none);
    add_row(make_item(MODE_LOOKUP, -16'sd32767, '0, '0, '0), 0, none);
    add_row(make_item(MODE_APPEND, -16'sd99, 32'hFFFFFFFF, 32'h0, 32'h0), 1,
            color_item('0, ST_APPENDED));
    add_row(make_item(MODE_APPEND, 16'sd0, 32'h80808080, 32'h01020304,
            32'hFFFFFFFF), 1, color_item('0, ST_APPENDED));
    add_row(make_item(MODE_APPEND, 16'sd10, 32'h00000000, 32'hDEADBEEF,
            32'h55AA55AA), 1, color_item('0, ST_APPENDED));
    add_row(make_item(MODE_LOOKUP, 16'sd5, '0, '0, '0), 0, none);
    add_row(make_item(MODE_LOOKUP, 16'sd9, '0, '0, '0), 0, none);
    add_row(make_item(MODE_APPEND, 16'sd1000, '1, '0, '1), 1,
            color_item('0, ST_APPENDED));
    add_row(make_item(MODE_APPEND, 16'sd30000, 32'h11111111, 32'h22222222,
            32'h33333333), 1, color_item('0, ST_APPENDED));
    add_row(make_item(MODE_APPEND, 16'sh7FFF, 32'hCAFEF00D, 32'h0BADC0DE,
            32'h00FF00FF), 1, color_item('0, ST_APPENDED));
    // table full
    add_row(make_item(MODE_APPEND, 16'sh7FFF, '1, '1, '1), 1,
            color_item('0, ST_REJECTED));
    add_row(make_item(MODE_LOOKUP, 16'sh7FFF, '0, '0, '0), 1,
            color_item(32'h0BADC0DE, ST_COLOR));
    add_row(make_item(MODE_LOOKUP, 16'sh7FFE, '0, '0, '0), 0, none);
    add_row(make_item(MODE_LOOKUP, 16'sd20000, '0, '0, '0), 0, none);
    add_row(make_item(MODE_LOOKUP, -16'sd50, '0, '0, '0), 0, none);
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    return POS_W'($urandom);
  endfunction

  // Send one item and record its prediction
  task automatic send_item(in_item_t it, bit chk, out_item_t want);
    out_item_t p;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    p = map_item(it);
    if (chk && p !== want)
      $display("%0t: table row mismatch: expected %h, actual prediction %h",
               $time, want, p);
    if (chk && p !== want) error_count++;
    expected_colors.push_back(chk ? want : p);
  endtask

  // Result side: random stalls plus one long hold
  initial begin
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_results = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_item_t want;
      result_count++;
      if (expected_colors.size() == 0) begin
        $display("%0t: result with none expected: actual %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        if (out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue || out_data.opacity !== want.opacity ||
            out_data.status !== want.status) begin
          $display("%0t: mismatch: expected r%h g%h b%h a%h st%0d, actual r%h g%h b%h a%h st%0d",
                   $time, want.red, want.green, want.blue, want.opacity, want.status,
                   out_data.red, out_data.green, out_data.blue, out_data.opacity,
                   out_data.status);
          error_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #5ms;
    $display("color_ramp_lookup regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    in_item_t it;
    out_item_t none;
    int sent;
    int k;
    longint step;
    none = '0;
    error_count = 0; result_count = 0; ramp_count = 0;
    lookup_count = 0; append_count = 0; reject_count = 0; blend_count = 0;
    quiet_phase = 1'b0; hold_results = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].has_check,
                directed_rows[i].want);

    // Random part: lookups near held breakpoints and anywhere else.
    // Resetting the table is not possible, so the table stays full after the
    // directed part; appends keep exercising the full-table reject.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 150) hold_results = 1'b1;
      if (sent >= RANDOM_ITEMS - 80) quiet_phase = 1'b1;
      k = $urandom_range(0, 9);
      if (k == 0) begin
        it = make_item(MODE_APPEND, rand_pos(), $urandom, $urandom, $urandom);
      end else if (k < 4) begin
        // near a held breakpoint
        int j;
        j = $urandom_range(0, ramp_count - 1);
        step = $urandom_range(0, 4);
        it = make_item(MODE_LOOKUP,
                       POS_W'(longint'(ramp_pos[j]) + step - 2),
                       $urandom, $urandom, $urandom);
      end else begin
        it = make_item(MODE_LOOKUP, rand_pos(), $urandom, $urandom, $urandom);
      end
      send_item(it, 0, none);
      sent++;
    end
    in_valid <= 1'b0;

    while (expected_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Covered %0d lookups (%0d blended), %0d appends, %0d rejects; %0d results.",
             lookup_count, blend_count, append_count, reject_count, result_count);
    if (error_count == 0) begin
      $display("color_ramp_lookup regression: pass");
    end else begin
      $display("color_ramp_lookup regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/crl_pkg.sv
rtl/crl_ram.sv
rtl/crl_div.sv
rtl/color_ramp_lookup.sv
sim/color_ramp_lookup_test.sv
